@@ hdl/cbc_pkg.sv @@
// shared types and constants for the cartridge bank controller
// used by cbc_cfg_regs, cbc_mapper and cartridge_bank_controller; no dependencies
package cbc_pkg;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int ROM_BANK_W  = 8;
  localparam int RAM_BANK_W  = 2;
  localparam int ROM_CNT_W   = 9;
  localparam int RAM_CNT_W   = 3;
  localparam int OFFSET_W    = 13;
  localparam int CLK_IDX_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTRL_TYPE = 3'd0,
    CFG_ROM_COUNT = 3'd1,
    CFG_RAM_COUNT = 3'd2,
    CFG_RAM_SIZE  = 3'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    CTRL_NONE = 2'd0,
    CTRL_MBC1 = 2'd1,
    CTRL_MBC2 = 2'd2,
    CTRL_MBC3 = 2'd3
  } ctrl_type_t;

  typedef enum logic [1:0] {
    MODE_ROM   = 2'd0,
    MODE_RAM   = 2'd1,
    MODE_CLOCK = 2'd2
  } bank_mode_t;

  localparam logic [1:0] RAM_SIZE_2KB = 2'd1;

  typedef struct packed {
    ctrl_type_t           ctrl_type;
    logic [ROM_CNT_W-1:0] rom_count;
    logic [RAM_CNT_W-1:0] ram_count;
    logic [1:0]           ram_size;
  } cbc_cfg_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_enabled;
    bank_mode_t            mode;
    logic                  ram_write;
    logic [OFFSET_W-1:0]   ram_offset;
    logic [DATA_W-1:0]     write_data;
    logic                  clock_write;
    logic [CLK_IDX_W-1:0]  clock_index;
  } cbc_result_t;

endpackage

@@ hdl/cbc_cfg_regs.sv @@
// configuration registers of the cartridge bank controller
// depends on cbc_pkg
module cbc_cfg_regs
  import cbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cbc_cfg_t              cfg
);

  cbc_cfg_t cfg_r;
  cbc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CTRL_TYPE: cfg_nxt.ctrl_type = ctrl_type_t'(cfg_data[1:0]);
        CFG_ROM_COUNT: cfg_nxt.rom_count = cfg_data[ROM_CNT_W-1:0];
        CFG_RAM_COUNT: cfg_nxt.ram_count = cfg_data[RAM_CNT_W-1:0];
        CFG_RAM_SIZE:  cfg_nxt.ram_size  = cfg_data[1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ctrl_type: CTRL_NONE, rom_count: '0, ram_count: '0, ram_size: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/cbc_mapper.sv @@
// bank registers and the per-write update logic of the cartridge bank controller
// depends on cbc_pkg
module cbc_mapper
  import cbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              commit,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] data,
  input  cbc_cfg_t          cfg,
  output cbc_result_t       result
);

  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  ram_en_r, ram_en_nxt;
  bank_mode_t            mode_r, mode_nxt;
  logic [CLK_IDX_W-1:0]  clk_sel_r, clk_sel_nxt;

  logic                  in_ram;
  logic                  size_ok;
  logic                  enable_code;
  logic                  rom_multi;
  logic [2:0]            region;
  logic [ROM_BANK_W-1:0] rom_req;
  logic                  rom_pick;
  logic [RAM_BANK_W-1:0] ram_req;
  logic                  ram_pick;
  logic [4:0]            low5;
  logic [3:0]            low4;
  logic [6:0]            low7;
  logic                  rw;
  logic                  cw;
  logic [DATA_W-1:0]     wd;

  assign region      = address[15:13];
  assign in_ram      = (region == 3'b101);
  assign enable_code = (data[3:0] == 4'ha);
  assign rom_multi   = (cfg.rom_count > 9'd1);
  assign low5        = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
  assign low4        = (data[3:0] == 4'd0) ? 4'd1 : data[3:0];
  assign low7        = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];

  // size code 1 is a 2 KB part, codes 2 and 3 open the whole window
  assign size_ok = (cfg.ram_size == RAM_SIZE_2KB) ? (address < 16'ha800) : cfg.ram_size[1];

  always_comb begin
    rom_req      = rom_bank_r;
    rom_pick     = 1'b0;
    ram_req      = ram_bank_r;
    ram_pick     = 1'b0;
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    clk_sel_nxt  = clk_sel_r;
    rw           = 1'b0;
    cw           = 1'b0;
    wd           = '0;
    case (cfg.ctrl_type)
      CTRL_NONE: begin
        if (in_ram && size_ok) begin
          rw = 1'b1;
          wd = data;
        end
      end
      CTRL_MBC1: begin
        case (region)
          3'd0: ram_en_nxt = enable_code;
          3'd1: begin
            if (rom_multi) begin
              rom_req  = {1'b0, rom_bank_r[6:5], low5};
              rom_pick = 1'b1;
            end
          end
          3'd2: begin
            if (mode_r == MODE_ROM && rom_multi) begin
              rom_req  = {1'b0, data[1:0], rom_bank_r[4:0]};
              rom_pick = 1'b1;
            end else if (mode_r == MODE_RAM && cfg.ram_count > 3'd1) begin
              ram_req  = data[1:0];
              ram_pick = 1'b1;
            end
          end
          3'd3: mode_nxt = bank_mode_t'({1'b0, data[0]});
          3'd5: begin
            if (ram_en_r && cfg.ram_count != 3'd0 && size_ok) begin
              rw = 1'b1;
              wd = data;
            end
          end
          default: ;
        endcase
      end
      CTRL_MBC2: begin
        // address bit 8 splits the enable and bank registers
        if (region == 3'd0 && !address[8]) begin
          ram_en_nxt = enable_code;
        end else if (region == 3'd1 && address[8]) begin
          rom_req  = {4'd0, low4};
          rom_pick = 1'b1;
        end else if (address[15:9] == 7'b1010000 && ram_en_r) begin
          rw = 1'b1;
          wd = {4'd0, data[3:0]};
        end
      end
      default: begin
        case (region)
          3'd0: ram_en_nxt = enable_code;
          3'd1: begin
            if (rom_multi) begin
              rom_req  = {1'b0, low7};
              rom_pick = 1'b1;
            end
          end
          3'd2: begin
            if (data < 8'h04) begin
              mode_nxt = MODE_RAM;
              ram_req  = data[1:0];
              ram_pick = 1'b1;
            end else if (data > 8'h07 && data < 8'h0d) begin
              mode_nxt    = MODE_CLOCK;
              clk_sel_nxt = data[2:0];
            end
          end
          3'd5: begin
            if (mode_r == MODE_RAM && ram_en_r) begin
              rw = 1'b1;
              wd = data;
            end else if (mode_r == MODE_CLOCK) begin
              cw = 1'b1;
              wd = data;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // bank requests at or above the present count are refused
  assign rom_bank_nxt = (rom_pick && ({1'b0, rom_req} < cfg.rom_count)) ? rom_req : rom_bank_r;
  assign ram_bank_nxt = (ram_pick && ({1'b0, ram_req} < cfg.ram_count)) ? ram_req : ram_bank_r;

  always_comb begin
    result.rom_bank    = rom_bank_nxt;
    result.ram_bank    = ram_bank_nxt;
    result.ram_enabled = ram_en_nxt;
    result.mode        = mode_nxt;
    result.ram_write   = rw;
    result.ram_offset  = rw ? address[OFFSET_W-1:0] : '0;
    result.write_data  = wd;
    result.clock_write = cw;
    result.clock_index = clk_sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 8'd1;
      ram_bank_r <= '0;
      ram_en_r   <= 1'b0;
      mode_r     <= MODE_ROM;
      clk_sel_r  <= '0;
    end else if (commit) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      mode_r     <= mode_nxt;
      clk_sel_r  <= clk_sel_nxt;
    end
  end

endmodule

@@ hdl/cartridge_bank_controller.sv @@
// cartridge bank controller top level: input register, mapper, result register
// depends on cbc_pkg, cbc_cfg_regs and cbc_mapper
// path: a write is captured in the input register, then moves into the result register, raising out_tvalid
// throughput: one write per cycle while out_tready is high; out_tready low holds the input and result register pair
// the bank registers update in the cycle the write moves into the result register
// reset (synchronous, rst_n low): rom bank 1, ram bank 0, ram disabled, rom mode, no controller
module cartridge_bank_controller
  import cbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] address, [23:16] data
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] rom_bank, [9:8] ram_bank, [10] ram_enabled, [12:11] mode, [13] ram_write,
  // [26:14] ram_offset, [34:27] write_data, [35] clock_write, [38:36] clock_index, [39] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cbc_cfg_t          cfg;
  cbc_result_t       result;
  cbc_result_t       out_r;
  logic              out_valid_r, out_valid_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              advance;
  logic              in_xfer;
  logic              commit;

  cbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbc_mapper u_mapper (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .address (s1_addr_r),
    .data    (s1_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign commit    = s1_valid_r && advance;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    if (commit) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.clock_index, out_r.clock_write, out_r.write_data,
                       out_r.ram_offset, out_r.ram_write, out_r.mode, out_r.ram_enabled,
                       out_r.ram_bank, out_r.rom_bank};

  // a write goes either to ram or to a clock register, never both
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.ram_write && out_r.clock_write))
    else $error("ram and clock write strobes both set");

  // clock register writes only happen in clock mode
  a_clock_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clock_write) |-> (out_r.mode == MODE_CLOCK))
    else $error("clock write outside clock mode");

  // with a real controller, ram writes need the enable latch
  a_ram_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.ram_write && cfg.ctrl_type != CTRL_NONE) |-> out_r.ram_enabled)
    else $error("ram write while ram disabled");

  // a stalled result is not overwritten by the next write
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

@@ tb/cartridge_bank_controller_tb.sv @@
// self-checking testbench for the cartridge bank controller: directed and random cpu writes
// under four controller types, with a model of the bank registers predicting each result
// depends on cbc_pkg and cartridge_bank_controller
module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 100;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_CTRL_TYPE;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [15:0] address, [23:16] data
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] rom_bank, [9:8] ram_bank, [10] ram_enabled, [12:11] mode, [13] ram_write,
  // [26:14] ram_offset, [34:27] write_data, [35] clock_write, [38:36] clock_index, [39] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  cartridge_bank_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // cartridge settings as seen by the model
  ctrl_type_t       cart_type = CTRL_NONE;
  logic [8:0]       rom_banks = '0;
  logic [2:0]       ram_banks = '0;
  logic [1:0]       size_code = '0;

  // bank register model
  logic [7:0]       rom_sel   = 8'd1;
  logic [1:0]       ram_sel   = '0;
  logic             ram_on    = 1'b0;
  bank_mode_t       bank_mode = MODE_ROM;
  logic [2:0]       clock_sel = '0;

  cbc_result_t      expected_maps[$];
  int               mismatch_count = 0;
  int               idle_cycles    = 0;

  // sender and receiver pacing
  logic             tx_steady    = 1'b0;
  int               burst_left   = 0;
  logic             rx_steady    = 1'b0;
  logic             hold_request = 1'b0;

  function automatic void select_rom(input logic [7:0] bank);
    if ({1'b0, bank} < rom_banks) rom_sel = bank;
  endfunction

  function automatic void select_ram(input logic [1:0] bank);
    if ({1'b0, bank} < ram_banks) ram_sel = bank;
  endfunction

  function automatic logic size_allows(input logic [15:0] a);
    if (size_code == RAM_SIZE_2KB) return a < 16'hA800;
    return size_code >= 2'd2;
  endfunction

  function automatic cbc_result_t predict_mapping(input logic [15:0] a, input logic [7:0] d);
    cbc_result_t r;
    logic        in_window;
    logic [7:0]  low;
    r = '0;
    in_window = (a >= 16'hA000) && (a < 16'hC000);
    case (cart_type)
      CTRL_NONE: begin
        if (in_window && size_allows(a)) begin
          r.ram_write  = 1'b1;
          r.write_data = d;
        end
      end
      CTRL_MBC1: begin
        if (a < 16'h2000) begin
          ram_on = (d[3:0] == 4'hA);
        end else if (a < 16'h4000) begin
          if (rom_banks > 9'd1) begin
            low = d & 8'h1F;
            if (low == 8'h00) low = 8'h01;
            select_rom(low | (rom_sel & 8'h60));
          end
        end else if (a < 16'h6000) begin
          // upper bits land on bank bits 5-6; clock mode leaves everything alone
          if (bank_mode == MODE_ROM && rom_banks > 9'd1)
            select_rom({1'b0, d[1:0], rom_sel[4:0]});
          else if (bank_mode == MODE_RAM && ram_banks > 3'd1)
            select_ram(d[1:0]);
        end else if (a < 16'h8000) begin
          bank_mode = d[0] ? MODE_RAM : MODE_ROM;
        end else if (in_window && ram_on && ram_banks != 3'd0 && size_allows(a)) begin
          r.ram_write  = 1'b1;
          r.write_data = d;
        end
      end
      CTRL_MBC2: begin
        if (a < 16'h2000) begin
          if (!a[8]) ram_on = (d[3:0] == 4'hA);
        end else if (a < 16'h4000) begin
          if (a[8]) begin
            low = d & 8'h0F;
            if (low == 8'h00) low = 8'h01;
            select_rom(low);
          end
        end else if (a >= 16'hA000 && a < 16'hA200) begin
          if (ram_on) begin
            r.ram_write  = 1'b1;
            r.write_data = d & 8'h0F;
          end
        end
      end
      default: begin
        if (a < 16'h2000) begin
          ram_on = (d[3:0] == 4'hA);
        end else if (a < 16'h4000) begin
          if (rom_banks > 9'd1) begin
            low = d & 8'h7F;
            if (low == 8'h00) low = 8'h01;
            select_rom(low);
          end
        end else if (a < 16'h6000) begin
          if (d < 8'h04) begin
            bank_mode = MODE_RAM;
            select_ram(d[1:0]);
          end else if (d > 8'h07 && d < 8'h0D) begin
            bank_mode = MODE_CLOCK;
            low = d - 8'h08;
            clock_sel = low[2:0];
          end
        end else if (in_window) begin
          if (bank_mode == MODE_RAM && ram_on) begin
            r.ram_write  = 1'b1;
            r.write_data = d;
          end else if (bank_mode == MODE_CLOCK) begin
            r.clock_write = 1'b1;
            r.write_data  = d;
          end
        end
      end
    endcase
    r.rom_bank    = rom_sel;
    r.ram_bank    = ram_sel;
    r.ram_enabled = ram_on;
    r.mode        = bank_mode;
    // window base has its low 13 bits clear, so the offset is the low address bits
    r.ram_offset  = r.ram_write ? a[12:0] : '0;
    r.clock_index = clock_sel;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // model update and result checking, all at the rising edge
  always @(posedge clk) begin : monitor
    cbc_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CTRL_TYPE: cart_type = ctrl_type_t'(cfg_data[1:0]);
          CFG_ROM_COUNT: rom_banks = cfg_data[8:0];
          CFG_RAM_COUNT: ram_banks = cfg_data[2:0];
          CFG_RAM_SIZE:  size_code = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_maps.push_back(predict_mapping(in_tdata[15:0], in_tdata[23:16]));
      if (out_tvalid && out_tready) begin
        if (expected_maps.size() == 0) begin
          $error("result transfer with no write outstanding: %h", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_maps.pop_front();
          check_field("rom_bank",    16'(want.rom_bank),    16'(out_tdata[7:0]));
          check_field("ram_bank",    16'(want.ram_bank),    16'(out_tdata[9:8]));
          check_field("ram_enabled", 16'(want.ram_enabled), 16'(out_tdata[10]));
          check_field("mode",        16'(want.mode),        16'(out_tdata[12:11]));
          check_field("ram_write",   16'(want.ram_write),   16'(out_tdata[13]));
          check_field("ram_offset",  16'(want.ram_offset),  16'(out_tdata[26:14]));
          check_field("write_data",  16'(want.write_data),  16'(out_tdata[34:27]));
          check_field("clock_write", 16'(want.clock_write), 16'(out_tdata[35]));
          check_field("clock_index", 16'(want.clock_index), 16'(out_tdata[38:36]));
          check_field("padding",     16'(1'b0),             16'(out_tdata[39]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random ready runs, a steady mode, and one long hold on request
  initial begin : result_sink
    int   run_left;
    logic run_ready;
    run_left  = 0;
    run_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else if (rx_steady) begin
        out_tready = 1'b1;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 2) != 0);
          run_left  = $urandom_range(1, 8);
        end
        run_left--;
        out_tready = run_ready;
      end
    end
  end

  // all tasks below start and end at a falling edge
  task automatic pace();
    int gap;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        in_tvalid = 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    pace();
    in_tvalid = 1'b1;
    in_tdata  = {data, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_maps.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input ctrl_type_t kind, input logic [8:0] roms,
                            input logic [2:0] rams, input logic [1:0] size);
    drain();
    write_reg(CFG_CTRL_TYPE, CFG_DATA_W'(kind));
    write_reg(CFG_ROM_COUNT, roms);
    write_reg(CFG_RAM_COUNT, CFG_DATA_W'(rams));
    write_reg(CFG_RAM_SIZE, CFG_DATA_W'(size));
  endtask

  // mostly register and ram window writes with useful data, some noise anywhere
  task automatic pick_cpu_write(output logic [15:0] addr, output logic [7:0] data);
    int region;
    region = $urandom_range(0, 99);
    data   = 8'($urandom_range(0, 255));
    if (region < 15) begin
      addr = 16'($urandom_range(0, 16'h1FFF));
      if ($urandom_range(0, 1)) data = 8'(($urandom_range(0, 15) << 4) | 8'h0A);
    end else if (region < 35) begin
      addr = 16'($urandom_range(16'h2000, 16'h3FFF));
    end else if (region < 55) begin
      addr = 16'($urandom_range(16'h4000, 16'h5FFF));
      if ($urandom_range(0, 1)) data = 8'($urandom_range(0, 15));
    end else if (region < 62) begin
      addr = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (region < 75) begin
      addr = 16'($urandom_range(16'hA000, 16'hA1FF));
    end else if (region < 82) begin
      addr = 16'($urandom_range(16'hA7F0, 16'hA80F));
    end else if (region < 90) begin
      addr = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else begin
      addr = 16'($urandom_range(0, 16'hFFFF));
    end
  endtask

  task automatic test_no_controller();
    set_config(CTRL_NONE, 9'd2, 3'd0, RAM_SIZE_2KB);
    send_write(16'h0000, 8'h0A);
    send_write(16'hA7FF, 8'hFF);
    send_write(16'hA800, 8'h00);
    send_write(16'h9FFF, 8'h55);
    send_write(16'hFFFF, 8'hFF);
    set_config(CTRL_NONE, 9'd2, 3'd0, 2'd2);
    send_write(16'hBFFF, 8'h81);
    set_config(CTRL_NONE, 9'd2, 3'd0, 2'd0);
    send_write(16'hA000, 8'h12);
    set_config(CTRL_NONE, 9'd2, 3'd0, 2'd3);
    send_write(16'hA000, 8'h34);
  endtask

  task automatic test_mbc1_banking();
    set_config(CTRL_MBC1, 9'd256, 3'd4, 2'd3);
    send_write(16'h2000, 8'h00);   // zero bank reads as one
    send_write(16'h3FFF, 8'hFF);
    send_write(16'h4000, 8'h03);   // upper bits in rom mode
    send_write(16'h1FFF, 8'h0A);
    send_write(16'hA000, 8'hC3);
    send_write(16'h6000, 8'h01);
    send_write(16'h5FFF, 8'h02);
    send_write(16'hBFFF, 8'h5A);
    send_write(16'h0000, 8'h1B);   // wrong low nibble disables
    set_config(CTRL_MBC1, 9'd8, 3'd4, 2'd3);
    send_write(16'h2000, 8'h10);   // beyond the bank count, refused
  endtask

  task automatic test_mbc2_nibble_ram();
    set_config(CTRL_MBC2, 9'd16, 3'd1, 2'd0);
    send_write(16'h0100, 8'h0A);
    send_write(16'h0000, 8'h0A);
    send_write(16'h2100, 8'h00);
    send_write(16'h2000, 8'h05);
    send_write(16'hA1FF, 8'hFF);
    send_write(16'hA200, 8'h11);
  endtask

  task automatic test_mbc3_clock_select();
    set_config(CTRL_MBC3, 9'd128, 3'd4, 2'd3);
    send_write(16'h4000, 8'h03);
    send_write(16'h4000, 8'h0C);
    send_write(16'hA000, 8'h77);   // clock write without ram enable
    send_write(16'h4000, 8'h07);
    send_write(16'h2000, 8'h80);
    // mbc1 bank write while the mode is still the clock mode
    drain();
    write_reg(CFG_CTRL_TYPE, CFG_DATA_W'(CTRL_MBC1));
    send_write(16'h4000, 8'h01);
  endtask

  task automatic test_backpressure();
    logic [15:0] addr;
    logic [7:0]  data;
    set_config(CTRL_MBC3, 9'd256, 3'd4, 2'd3);
    tx_steady    = 1'b1;
    hold_request = 1'b1;
    repeat (24) begin
      pick_cpu_write(addr, data);
      send_write(addr, data);
    end
    tx_steady = 1'b0;
    drain();
  endtask

  task automatic test_random_phases();
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  roms;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 4:    roms = 9'd256;
        1:       roms = 9'd0;
        2:       roms = 9'd1;
        3:       roms = 9'd2;
        5:       roms = 9'd8;
        default: roms = 9'($urandom_range(2, 256));
      endcase
      set_config(ctrl_type_t'(phase % 4), roms,
                 3'((phase < 5) ? phase : $urandom_range(0, 4)), 2'($urandom_range(0, 3)));
      repeat (40) begin
        pick_cpu_write(addr, data);
        send_write(addr, data);
      end
    end
  endtask

  task automatic test_steady_stream();
    logic [15:0] addr;
    logic [7:0]  data;
    set_config(CTRL_MBC1, 9'd64, 3'd4, RAM_SIZE_2KB);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (40) begin
      pick_cpu_write(addr, data);
      send_write(addr, data);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : run
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_no_controller();
    test_mbc1_banking();
    test_mbc2_nibble_ram();
    test_mbc3_clock_select();
    test_backpressure();
    test_random_phases();
    test_steady_stream();
    drain();
    repeat (10) @(negedge clk);
    if (expected_maps.size() != 0) begin
      $error("%0d expected results never arrived", expected_maps.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
